@@ src/gfab_pkg.sv @@
// ---------------------------------------------------------------------------
// gfab_pkg
// Types, widths and helpers shared by the gradient fill and alpha blend
// pipeline.
// ---------------------------------------------------------------------------
package gfab_pkg;

  localparam int NCH       = 4;          // colour channels in a pixel (B, G, R, A)
  localparam int CH_W      = 8;
  localparam int PIX_W     = NCH * CH_W;
  localparam int POS_W     = 12;
  localparam int LEN_W     = 13;
  localparam int LEN_LIMIT = (1 << LEN_W) - 1;
  localparam int PROD_W    = CH_W + LEN_W;   // start * length
  localparam int DP_W      = 22;             // (start - end) * position, signed
  localparam int NUM_W     = PROD_W + 2;     // signed numerator
  localparam int DVD_W     = PROD_W + 1;     // 2 * num + L
  localparam int DVS_W     = LEN_W + 1;      // 2 * L
  localparam int BLD_W     = 2 * CH_W;       // 8x8 products
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int DIV_BITS   = 2;                 // quotient bits per stage
  localparam int DIV_STAGES = CH_W / DIV_BITS;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_START,
    REG_RAMP_END,
    REG_HORIZONTAL,
    REG_GRAD_WIDTH,
    REG_GRAD_HEIGHT,
    REG_TRANSPARENCY
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] ramp_start;
    logic [PIX_W-1:0] ramp_end;
    logic             horizontal;
    logic [LEN_W-1:0] grad_width;
    logic [LEN_W-1:0] grad_height;
  } grad_cfg_t;

  typedef struct packed {
    logic [NCH-1:0][DVD_W-1:0] dvd;
    logic [DVS_W-1:0]          dvs;
    logic [PIX_W-1:0]          dest;
  } div_in_t;

  typedef struct packed {
    logic [NCH-1:0][DVD_W-1:0] rem;
    logic [NCH-1:0][CH_W-1:0]  quo;
    logic [DVS_W-1:0]          dvs;
    logic [PIX_W-1:0]          dest;
  } div_stage_t;

  typedef struct packed {
    logic [NCH-1:0][CH_W-1:0] quo;
    logic [PIX_W-1:0]         dest;
  } div_out_t;

  // floor(x / 255), exact for any x up to 255 * 255
  function automatic logic [CH_W-1:0] div255(input logic [BLD_W-1:0] x);
    logic [BLD_W:0] s;
    s = (BLD_W+1)'(x) + (BLD_W+1)'(x >> CH_W) + (BLD_W+1)'(1);
    return s[BLD_W-1:CH_W];
  endfunction

endpackage

@@ src/gradient_fill_alpha_blend.sv @@
// ---------------------------------------------------------------------------
// gradient_fill_alpha_blend
// Linear gradient fill blended over a stream of destination pixels.
// ---------------------------------------------------------------------------
// Takes one pixel per clock and returns one blended pixel per clock, in order,
// while the output is not stalled. The pipeline is three stages of gradient
// arithmetic, the four-stage divider that rounds each gradient channel (two
// quotient bits per stage) and three stages of alpha scaling and blending. A
// stall on the output only holds the input once every stage in front of it
// holds a beat. Write the configuration registers only while no pixel is in
// flight.
module gradient_fill_alpha_blend import gfab_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [POS_W-1:0]     pos_x,
  input  logic [POS_W-1:0]     pos_y,
  input  logic [PIX_W-1:0]     back_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel
);

  grad_cfg_t       cfg;
  logic [CH_W-1:0] transparency;

  logic     itp_valid, div_stall;
  div_in_t  itp_data;
  logic     div_valid, bld_stall;
  div_out_t div_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_start   <= '0;
      cfg.ramp_end     <= '0;
      cfg.horizontal   <= 1'b1;
      cfg.grad_width   <= LEN_W'(1);
      cfg.grad_height  <= LEN_W'(1);
      transparency     <= CH_MAX;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RAMP_START:   cfg.ramp_start  <= cfg_data[PIX_W-1:0];
        REG_RAMP_END:     cfg.ramp_end    <= cfg_data[PIX_W-1:0];
        REG_HORIZONTAL:   cfg.horizontal  <= cfg_data[0];
        REG_GRAD_WIDTH:   cfg.grad_width  <= cfg_data[LEN_W-1:0];
        REG_GRAD_HEIGHT:  cfg.grad_height <= cfg_data[LEN_W-1:0];
        REG_TRANSPARENCY: transparency    <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  gfab_interp #(
    .MAX_DIM(MAX_DIM)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .back_pixel (back_pixel),
    .out_valid  (itp_valid),
    .out_stall  (div_stall),
    .out_data   (itp_data)
  );

  gfab_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (itp_valid),
    .in_stall  (div_stall),
    .in_data   (itp_data),
    .out_valid (div_valid),
    .out_stall (bld_stall),
    .out_data  (div_data)
  );

  gfab_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .transparency (transparency),
    .in_valid     (div_valid),
    .in_stall     (bld_stall),
    .in_data      (div_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel)
  );

  // the input only backs up behind a full pipe with a stalled output
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

@@ src/gfab_interp.sv @@
// ---------------------------------------------------------------------------
// gfab_interp
// Selects the gradient axis, forms the per-channel numerator of the linear
// gradient, clamps it and presents dividend and divisor for rounding.
// ---------------------------------------------------------------------------
module gfab_interp import gfab_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  grad_cfg_t        cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  input  logic [PIX_W-1:0] back_pixel,
  output logic             out_valid,
  input  logic             out_stall,
  output div_in_t          out_data
);

  localparam int NSTG = 3;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'((MAX_DIM > LEN_LIMIT) ? LEN_LIMIT : MAX_DIM);

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // stage A: axis select
  logic [LEN_W-1:0] len_a, len_a_next;
  logic [POS_W-1:0] pos_a, pos_a_next;
  logic [PIX_W-1:0] dest_a;
  logic [LEN_W-1:0] len_raw;

  // stage B: products
  logic        [PROD_W-1:0] sl_b [NCH];
  logic        [PROD_W-1:0] sl_b_next [NCH];
  logic signed [DP_W-1:0]   dp_b [NCH];
  logic signed [DP_W-1:0]   dp_b_next [NCH];
  logic        [LEN_W-1:0]  len_b;
  logic        [PIX_W-1:0]  dest_b;

  // stage C: clamp and form dividend
  div_in_t     divin_next;
  logic [PROD_W-1:0] full;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    len_raw    = cfg.horizontal ? cfg.grad_width : cfg.grad_height;
    pos_a_next = cfg.horizontal ? pos_x : pos_y;
    if (len_raw == '0) begin
      len_a_next = LEN_W'(1);
    end else if (len_raw > LEN_MAX) begin
      len_a_next = LEN_MAX;
    end else begin
      len_a_next = len_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      len_a  <= len_a_next;
      pos_a  <= pos_a_next;
      dest_a <= back_pixel;
    end
  end

  always_comb begin
    logic        [CH_W-1:0] s;
    logic        [CH_W-1:0] e;
    logic signed [CH_W:0]   diff;
    logic signed [POS_W:0]  ps;
    ps = $signed({1'b0, pos_a});
    for (int c = 0; c < NCH; c++) begin
      s    = cfg.ramp_start[c*CH_W +: CH_W];
      e    = cfg.ramp_end[c*CH_W +: CH_W];
      diff = $signed({1'b0, s}) - $signed({1'b0, e});
      sl_b_next[c] = PROD_W'(s) * PROD_W'(len_a);
      dp_b_next[c] = DP_W'(diff) * DP_W'(ps);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int c = 0; c < NCH; c++) begin
        sl_b[c] <= sl_b_next[c];
        dp_b[c] <= dp_b_next[c];
      end
      len_b  <= len_a;
      dest_b <= dest_a;
    end
  end

  always_comb begin
    logic signed [NUM_W-1:0]  num;
    logic        [PROD_W-1:0] numc;
    full = PROD_W'({len_b, 8'b0}) - PROD_W'(len_b);
    divin_next.dvs  = {len_b, 1'b0};
    divin_next.dest = dest_b;
    for (int c = 0; c < NCH; c++) begin
      num = $signed({2'b0, sl_b[c]}) - NUM_W'(dp_b[c]);
      // clamp the extrapolated value into the channel range
      if (num < 0) begin
        numc = '0;
      end else if (num > $signed({2'b0, full})) begin
        numc = full;
      end else begin
        numc = num[PROD_W-1:0];
      end
      divin_next.dvd[c] = {numc, 1'b0} + DVD_W'(len_b);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_data <= divin_next;
    end
  end

  // the quotient must fit a channel for every clamped numerator
  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> (out_data.dvd[0] < {out_data.dvs, 8'b0})
                 && (out_data.dvd[1] < {out_data.dvs, 8'b0})
                 && (out_data.dvd[2] < {out_data.dvs, 8'b0})
                 && (out_data.dvd[3] < {out_data.dvs, 8'b0}))
    else $error("gradient dividend out of range");

endmodule

@@ src/gfab_div.sv @@
// ---------------------------------------------------------------------------
// gfab_div
// Pipelined restoring divider, four channel lanes sharing one divisor,
// two quotient bits resolved in each stage.
// ---------------------------------------------------------------------------
module gfab_div import gfab_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  div_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output div_out_t out_data
);

  localparam int NSTG = DIV_STAGES;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  div_stage_t      stg [NSTG];

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    div_stage_t src;
    div_stage_t stg_next;

    if (s == 0) begin : g_first
      always_comb begin
        src.rem  = in_data.dvd;
        src.quo  = '0;
        src.dvs  = in_data.dvs;
        src.dest = in_data.dest;
      end
    end else begin : g_rest
      assign src = stg[s-1];
    end

    always_comb begin
      logic [DVD_W-1:0] sh;
      stg_next = src;
      for (int c = 0; c < NCH; c++) begin
        for (int j = 0; j < DIV_BITS; j++) begin
          sh = DVD_W'(src.dvs) << (CH_W - 1 - DIV_BITS * s - j);
          if (stg_next.rem[c] >= sh) begin
            stg_next.rem[c] = stg_next.rem[c] - sh;
            stg_next.quo[c][CH_W - 1 - DIV_BITS * s - j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        stg[s] <= stg_next;
      end
    end
  end

  assign out_data.quo  = stg[NSTG-1].quo;
  assign out_data.dest = stg[NSTG-1].dest;

  // after the last stage every remainder is below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> (stg[NSTG-1].rem[0] < DVD_W'(stg[NSTG-1].dvs))
                 && (stg[NSTG-1].rem[1] < DVD_W'(stg[NSTG-1].dvs))
                 && (stg[NSTG-1].rem[2] < DVD_W'(stg[NSTG-1].dvs))
                 && (stg[NSTG-1].rem[3] < DVD_W'(stg[NSTG-1].dvs)))
    else $error("divider remainder not reduced");

  // a held first stage keeps its beat
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    !adv[0] |=> vld[0] && $stable(stg[0]))
    else $error("divider stage lost a held beat");

endmodule

@@ src/gfab_blend.sv @@
// ---------------------------------------------------------------------------
// gfab_blend
// Scales gradient alpha by the global transparency and blends the gradient
// colour over the destination pixel; destination alpha passes through.
// ---------------------------------------------------------------------------
module gfab_blend import gfab_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CH_W-1:0]  transparency,
  input  logic             in_valid,
  output logic             in_stall,
  input  div_out_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pixel
);

  localparam int NSTG = 3;
  localparam int NCOL = NCH - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // stage 1: transparency * gradient alpha
  logic [BLD_W-1:0]           ta;
  logic [NCOL-1:0][CH_W-1:0]  grad1;
  logic [PIX_W-1:0]           dest1;

  // stage 2: blend products
  logic [BLD_W-1:0] pg [NCOL];
  logic [BLD_W-1:0] pg_next [NCOL];
  logic [BLD_W-1:0] pd [NCOL];
  logic [BLD_W-1:0] pd_next [NCOL];
  logic [CH_W-1:0]  alpha2;
  logic [CH_W-1:0]  a_eff;

  logic [PIX_W-1:0] out_pixel_next;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ta    <= BLD_W'(transparency) * BLD_W'(in_data.quo[NCH-1]);
      grad1 <= in_data.quo[NCOL-1:0];
      dest1 <= in_data.dest;
    end
  end

  always_comb begin
    a_eff = div255(ta);
    for (int c = 0; c < NCOL; c++) begin
      pg_next[c] = BLD_W'(grad1[c]) * BLD_W'(a_eff);
      pd_next[c] = BLD_W'(dest1[c*CH_W +: CH_W]) * BLD_W'(CH_MAX - a_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int c = 0; c < NCOL; c++) begin
        pg[c] <= pg_next[c];
        pd[c] <= pd_next[c];
      end
      alpha2 <= dest1[PIX_W-1 -: CH_W];
    end
  end

  always_comb begin
    logic [BLD_W:0] sum;
    out_pixel_next[PIX_W-1 -: CH_W] = alpha2;
    for (int c = 0; c < NCOL; c++) begin
      sum = (BLD_W+1)'(pg[c]) + (BLD_W+1)'(pd[c]);
      out_pixel_next[c*CH_W +: CH_W] = div255(sum[BLD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_pixel <= out_pixel_next;
    end
  end

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// Testbench for gradient_fill_alpha_blend
// Writes gradient settings between bursts of pixels and predicts every
// blended pixel in the testbench. Each output beat is checked in order
// against the prediction. Both sides stall at random, and one long output
// hold-off fills the pipeline.
// ---------------------------------------------------------------------------
module testbench;
  import gfab_pkg::*;

  localparam int LEN_CAP       = 4096;
  localparam int HOLD_CYCLES   = 80;
  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_BEATS   = 100;
  localparam int QUIET_PHASE   = 3;
  localparam int BURST_BEATS   = 60;

  // indexes past the last register; writes to them are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] from_color;
    logic [PIX_W-1:0] to_color;
    logic             along_x;
    logic [LEN_W-1:0] width;
    logic [LEN_W-1:0] height;
    logic [CH_W-1:0]  alpha_scale;
  } fill_setup_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [PIX_W-1:0]     back_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_pixel;

  fill_setup_t      setup;
  logic [PIX_W-1:0] pending_pixels[$];
  int               fail_count;
  int               stuck_cycles;
  bit               sender_gaps;
  bit               take_gaps;
  bit               hold_req;

  gradient_fill_alpha_blend #(.MAX_DIM(LEN_CAP)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .back_pixel (back_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel  (out_pixel)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---- prediction ----

  function automatic int axis_length(input fill_setup_t s);
    int len;
    len = s.along_x ? int'(s.width) : int'(s.height);
    if (len == 0) len = 1;
    if (len > LEN_CAP) len = LEN_CAP;
    return len;
  endfunction

  function automatic logic [CH_W-1:0] ramp_level(input longint s, input longint e,
                                                 input longint p, input longint len);
    longint num;
    num = s * len - (s - e) * p;
    if (num < 0) return '0;
    if (num > 255 * len) return CH_MAX;
    return CH_W'((2 * num + len) / (2 * len));
  endfunction

  function automatic logic [CH_W-1:0] mix_channel(input int g, input int d, input int a);
    return CH_W'((g * a + d * (255 - a)) / 255);
  endfunction

  function automatic logic [PIX_W-1:0] blended_pixel(input fill_setup_t s,
                                                     input logic [POS_W-1:0] x,
                                                     input logic [POS_W-1:0] y,
                                                     input logic [PIX_W-1:0] d);
    longint           len;
    longint           p;
    logic [CH_W-1:0]  ramp[NCH];
    int               a;
    logic [PIX_W-1:0] pix;
    len = axis_length(s);
    p = s.along_x ? longint'(x) : longint'(y);
    for (int k = 0; k < NCH; k++)
      ramp[k] = ramp_level(s.from_color[k*CH_W +: CH_W], s.to_color[k*CH_W +: CH_W], p, len);
    a = (int'(s.alpha_scale) * int'(ramp[NCH-1])) / 255;
    pix = d;
    for (int k = 0; k < NCH - 1; k++)
      pix[k*CH_W +: CH_W] = mix_channel(ramp[k], d[k*CH_W +: CH_W], a);
    return pix;
  endfunction

  // ---- driving ----

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Upper data bits of the narrow registers carry noise that must be dropped.
  task automatic apply_config(input fill_setup_t s);
    write_reg(REG_RAMP_START, s.from_color);
    write_reg(REG_RAMP_END, s.to_color);
    write_reg(REG_HORIZONTAL, {31'($urandom), s.along_x});
    write_reg(REG_GRAD_WIDTH, {19'($urandom), s.width});
    write_reg(REG_GRAD_HEIGHT, {19'($urandom), s.height});
    write_reg(REG_TRANSPARENCY, {24'($urandom), s.alpha_scale});
    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
    setup = s;
  endtask

  // Leave valid high on return; the next send or drain decides what follows.
  task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [PIX_W-1:0] d);
    while (sender_gaps && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    pos_x      <= x;
    pos_y      <= y;
    back_pixel <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_length;
    case ($urandom_range(9))
      0:       return '0;
      1:       return LEN_W'(LEN_CAP);
      2:       return LEN_W'($urandom_range(8191, LEN_CAP + 1));
      3:       return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic fill_setup_t random_setup;
    fill_setup_t s;
    s.from_color = $urandom;
    s.to_color   = $urandom;
    s.along_x    = $urandom_range(1);
    s.width      = pick_length();
    s.height     = pick_length();
    case ($urandom_range(4))
      0:       s.alpha_scale = '0;
      1:       s.alpha_scale = CH_MAX;
      default: s.alpha_scale = CH_W'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input int len);
    case ($urandom_range(9))
      0:       return POS_W'($urandom);
      1:       return POS_W'(len - 1);
      2:       return (len <= 4095) ? POS_W'($urandom_range(4095, len)) : '1;
      default: return POS_W'($urandom_range(len - 1, 0));
    endcase
  endfunction

  task automatic send_random;
    logic [POS_W-1:0] along;
    logic [POS_W-1:0] across;
    along  = pick_position(axis_length(setup));
    across = POS_W'($urandom);
    if (setup.along_x) send_pixel(along, across, $urandom);
    else send_pixel(across, along, $urandom);
  endtask

  // ---- tests ----

  // after reset the gradient is fully transparent, so pixels pass unchanged
  task automatic test_reset_state;
    send_pixel('0, '1, '0);
    send_pixel('1, '0, '1);
    send_pixel(12'h5A5, 12'hA5A, 32'h8142_C3E7);
    drain;
  endtask

  task automatic test_directed;
    fill_setup_t s;
    s.from_color  = 32'hC0FF_0080;
    s.to_color    = 32'h4000_FF7F;
    s.along_x     = 1'b1;
    s.width       = 13'd16;
    s.height      = 13'd4096;
    s.alpha_scale = CH_MAX;
    apply_config(s);
    send_pixel(12'd0, 12'hFFF, 32'h0000_0000);
    send_pixel(12'd15, 12'd0, 32'hFFFF_FFFF);
    send_pixel(12'd16, 12'h555, 32'h1234_5678);   // first position past the far end
    send_pixel(12'hFFF, 12'hAAA, 32'h80C0_E0F0);  // far past: clamps both ways
    send_pixel(12'd8, 12'd7, 32'hFF00_FF00);
    drain;
    // zero width acts as one
    s.width = '0;
    apply_config(s);
    send_pixel(12'd0, 12'd3, 32'h7F80_01FE);
    send_pixel(12'd1, 12'd3, 32'h0102_0304);
    send_pixel(12'hFFF, 12'hFFF, 32'hFEDC_BA98);
    drain;
    // vertical, oversized height, fully transparent
    s.along_x     = 1'b0;
    s.width       = 13'd4096;
    s.height      = '1;
    s.alpha_scale = '0;
    apply_config(s);
    send_pixel(12'hFFF, 12'd0, 32'hDEAD_BEEF);
    send_pixel(12'd0, 12'hFFF, 32'h0F0F_0F0F);
    send_pixel(12'd5, 12'd2048, 32'hF0F0_F0F0);
    drain;
    s.from_color  = '1;
    s.to_color    = '0;
    s.height      = 13'd4097;
    s.alpha_scale = 8'd128;
    apply_config(s);
    send_pixel(12'd9, 12'hFFF, 32'h3366_99CC);
    send_pixel(12'd9, 12'd0, 32'hCC99_6633);
    drain;
    s.from_color  = '0;
    s.to_color    = '1;
    s.height      = 13'd4096;
    s.alpha_scale = 8'd1;
    apply_config(s);
    send_pixel(12'hABC, 12'hFFF, 32'hFFFF_FFFF);
    send_pixel(12'h123, 12'd2048, 32'h0000_0000);
    drain;
  endtask

  task automatic test_random_settings;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_config(random_setup());
      sender_gaps = (ph != QUIET_PHASE);
      take_gaps   = (ph != QUIET_PHASE);
      repeat (PHASE_BEATS) send_random;
      drain;
    end
    sender_gaps = 1'b1;
    take_gaps   = 1'b1;
  endtask

  // hold the output long enough that the pipeline fills and stalls the input
  task automatic test_output_holdoff;
    fill_setup_t s;
    s = random_setup();
    s.width  = 13'd40;
    s.height = 13'd40;
    apply_config(s);
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    repeat (BURST_BEATS) send_random;
    drain;
    sender_gaps = 1'b1;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    back_pixel  = '0;
    fail_count  = 0;
    sender_gaps = 1'b1;
    take_gaps   = 1'b1;
    hold_req    = 1'b0;
    setup.from_color  = '0;
    setup.to_color    = '0;
    setup.along_x     = 1'b1;
    setup.width       = 13'd1;
    setup.height      = 13'd1;
    setup.alpha_scale = CH_MAX;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state;
    test_directed;
    test_random_settings;
    test_output_holdoff;
    drain;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---- output side ----

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= take_gaps && ($urandom_range(99) < 14);
    end
  end

  // predict each pixel as it is taken in
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_pixels.push_back(blended_pixel(setup, pos_x, pos_y, back_pixel));
  end

  always @(posedge clk) begin : check_out
    logic [PIX_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("out_pixel beat with nothing outstanding: expected none, actual %h",
               out_pixel);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want) begin
          $error("out_pixel mismatch: expected %h, actual %h", want, out_pixel);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
